[src/eard_pkg.sv]
// ----------------------------------------------------------------------------
// eard_pkg
// Shared types and constants of the Euler angle rate differentiator.
// ----------------------------------------------------------------------------
`default_nettype none

package eard_pkg;

    // field widths
    localparam int ANGLE_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int RATE_BITS      = 32;
    localparam int RATE_SHIFT_DEF = 16;

    // angle difference after the heading wrap, with room for the pi constants
    localparam int DIFF_W = (ANGLE_BITS + 2 > 18) ? ANGLE_BITS + 2 : 18;
    // signed tick difference
    localparam int TICK_W = TIME_BITS + 1;

    // pi and two pi, 13 fraction bits
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] heading_angle;
        logic        [TIME_BITS-1:0]  sample_time;
    } t_in_item;

    typedef struct packed {
        logic                         rate_valid;
        logic        [RATE_BITS-1:0]  rate_time;
        logic signed [RATE_BITS-1:0]  roll_rate;
        logic signed [RATE_BITS-1:0]  pitch_rate;
        logic signed [RATE_BITS-1:0]  heading_rate;
    } t_out_item;

    // classified work for the back part
    typedef struct packed {
        logic                     valid;       // middle slot holds a sample
        logic                     ticks_zero;  // hold previous rates
        logic [RATE_BITS-1:0]     rate_time;
        logic signed [TICK_W-1:0] ticks;
        logic signed [DIFF_W-1:0] d_roll;
        logic signed [DIFF_W-1:0] d_pitch;
        logic signed [DIFF_W-1:0] d_head;      // already wrapped
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_STORE,
        BK_OUT
    } t_back_state;

endpackage

`default_nettype wire

[src/eard_front.sv]
// ----------------------------------------------------------------------------
// eard_front
// Sample window and difference selection; emits one command per item.
// ----------------------------------------------------------------------------
`default_nettype none

module eard_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire eard_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output eard_pkg::t_cmd         o_cmd,
    output logic                   o_cmd_push
);
    import eard_pkg::*;

    localparam logic signed [DIFF_W-1:0] PI_D     = DIFF_W'(PI_Q13);
    localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(TWO_PI_Q13);

    // kept slots: index 0 is the older sample of the next window, 1 the newest
    logic signed [ANGLE_BITS-1:0] r_roll  [2];
    logic signed [ANGLE_BITS-1:0] r_pitch [2];
    logic signed [ANGLE_BITS-1:0] r_head  [2];
    logic        [TIME_BITS-1:0]  r_time  [2];

    logic                         accept;
    logic signed [ANGLE_BITS-1:0] a_hi [3];
    logic signed [ANGLE_BITS-1:0] a_lo [3];
    logic        [TIME_BITS-1:0]  t_hi;
    logic        [TIME_BITS-1:0]  t_lo;
    logic signed [TICK_W-1:0]     ticks;
    logic signed [DIFF_W-1:0]     d_head_raw;
    logic signed [DIFF_W-1:0]     d_head;

    assign accept     = i_push & ~i_q_full;
    assign o_cmd_push = accept;

    // window shift on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_roll[k]  <= '0;
                r_pitch[k] <= '0;
                r_head[k]  <= '0;
                r_time[k]  <= '0;
            end
        end else if (accept) begin
            r_roll[0]  <= r_roll[1];
            r_pitch[0] <= r_pitch[1];
            r_head[0]  <= r_head[1];
            r_time[0]  <= r_time[1];
            r_roll[1]  <= i_item.roll_angle;
            r_pitch[1] <= i_item.pitch_angle;
            r_head[1]  <= i_item.heading_angle;
            r_time[1]  <= i_item.sample_time;
        end
    end

    // pick the pair: forward with no older sample, backward on flush,
    // central otherwise (window before the shift: older=r[0], middle=r[1], new=item)
    always_comb begin
        if (r_time[0] == '0) begin
            a_hi = '{i_item.roll_angle, i_item.pitch_angle, i_item.heading_angle};
            a_lo = '{r_roll[1], r_pitch[1], r_head[1]};
            t_hi = i_item.sample_time;
            t_lo = r_time[1];
        end else if (i_item.sample_time == '0) begin
            a_hi = '{r_roll[1], r_pitch[1], r_head[1]};
            a_lo = '{r_roll[0], r_pitch[0], r_head[0]};
            t_hi = r_time[1];
            t_lo = r_time[0];
        end else begin
            a_hi = '{i_item.roll_angle, i_item.pitch_angle, i_item.heading_angle};
            a_lo = '{r_roll[0], r_pitch[0], r_head[0]};
            t_hi = i_item.sample_time;
            t_lo = r_time[0];
        end
    end

    assign ticks = $signed({1'b0, t_hi}) - $signed({1'b0, t_lo});

    // heading difference wrapped once into plus or minus pi
    assign d_head_raw = DIFF_W'(a_hi[2]) - DIFF_W'(a_lo[2]);
    always_comb begin
        if (d_head_raw >= PI_D) begin
            d_head = d_head_raw - TWO_PI_D;
        end else if (d_head_raw <= -PI_D) begin
            d_head = d_head_raw + TWO_PI_D;
        end else begin
            d_head = d_head_raw;
        end
    end

    always_comb begin
        o_cmd.valid      = (r_time[1] != '0);
        o_cmd.ticks_zero = (ticks == '0);
        o_cmd.rate_time  = RATE_BITS'(r_time[1]);
        o_cmd.ticks      = ticks;
        o_cmd.d_roll     = DIFF_W'(a_hi[0]) - DIFF_W'(a_lo[0]);
        o_cmd.d_pitch    = DIFF_W'(a_hi[1]) - DIFF_W'(a_lo[1]);
        o_cmd.d_head     = d_head;
    end

endmodule

`default_nettype wire

[src/eard_queue.sv]
// ----------------------------------------------------------------------------
// eard_queue
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module eard_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire eard_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output eard_pkg::t_cmd     o_cmd,
    output logic               o_empty
);
    import eard_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/eard_back.sv]
// ----------------------------------------------------------------------------
// eard_back
// Shared bit-serial divider for the three rates, held rates, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eard_back #(
    parameter int RATE_SHIFT = eard_pkg::RATE_SHIFT_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire eard_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    output eard_pkg::t_out_item o_item,
    output logic                o_empty,
    input  wire logic           i_pop
);
    import eard_pkg::*;

    localparam int NUM_W = DIFF_W + RATE_SHIFT;
    localparam int DEN_W = TICK_W;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int EXT_W = (NUM_W > 32) ? NUM_W + 1 : 34;
    localparam logic [EXT_W-1:0] MAG_NEG_LIM = EXT_W'(64'h8000_0000);
    localparam logic [EXT_W-1:0] MAG_POS_LIM = EXT_W'(64'h7FFF_FFFF);
    localparam logic signed [RATE_BITS-1:0] RATE_MAX = RATE_BITS'(64'h7FFF_FFFF);
    localparam logic signed [RATE_BITS-1:0] RATE_MIN = RATE_BITS'(64'h8000_0000);

    t_back_state                 r_state,    n_state;
    logic [1:0]                  r_lane,     n_lane;
    logic [CNT_W-1:0]            r_cnt,      n_cnt;
    logic [DEN_W-1:0]            r_rem,      n_rem;
    logic [NUM_W-1:0]            r_quo,      n_quo;
    logic [DEN_W-1:0]            r_den,      n_den;
    logic                        r_neg,      n_neg;
    t_cmd                        r_cmd,      n_cmd;
    logic signed [RATE_BITS-1:0] r_held [3];
    logic signed [RATE_BITS-1:0] n_held [3];
    logic                        r_out_full, n_out_full;
    t_out_item                   r_out,      n_out;

    logic signed [DIFF_W-1:0] lane_diff;
    logic        [DIFF_W-1:0] diff_mag;
    logic        [DEN_W:0]    rem_sh;
    logic        [DEN_W:0]    rem_sub;
    logic                     fits;
    logic        [EXT_W-1:0]  q_ext;
    logic signed [RATE_BITS-1:0] sat_rate;

    assign o_item  = r_out;
    assign o_empty = ~r_out_full;

    // operand of the current lane
    always_comb begin
        case (r_lane)
            2'd0:    lane_diff = r_cmd.d_roll;
            2'd1:    lane_diff = r_cmd.d_pitch;
            default: lane_diff = r_cmd.d_head;
        endcase
    end
    assign diff_mag = lane_diff[DIFF_W-1] ? DIFF_W'(-lane_diff) : DIFF_W'(lane_diff);

    // one restoring step per cycle
    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = (rem_sh >= {1'b0, r_den});

    // sign and saturation of the finished quotient
    assign q_ext = EXT_W'(r_quo);
    always_comb begin
        if (r_neg) begin
            sat_rate = (q_ext > MAG_NEG_LIM) ? RATE_MIN : RATE_BITS'(-q_ext);
        end else begin
            sat_rate = (q_ext > MAG_POS_LIM) ? RATE_MAX : RATE_BITS'(q_ext);
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_lane     = r_lane;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_den      = r_den;
        n_neg      = r_neg;
        n_cmd      = r_cmd;
        n_held     = r_held;
        n_out      = r_out;
        n_out_full = r_out_full & ~i_pop;
        o_cmd_pop  = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_lane    = 2'd0;
                    n_den     = i_cmd.ticks[TICK_W-1] ? DEN_W'(-i_cmd.ticks)
                                                      : DEN_W'(i_cmd.ticks);
                    n_state   = (i_cmd.valid && !i_cmd.ticks_zero) ? BK_LOAD : BK_OUT;
                end
            end
            BK_LOAD: begin
                n_quo   = NUM_W'(diff_mag) << RATE_SHIFT;
                n_rem   = '0;
                n_neg   = lane_diff[DIFF_W-1] ^ r_cmd.ticks[TICK_W-1];
                n_cnt   = CNT_W'(NUM_W);
                n_state = BK_DIV;
            end
            BK_DIV: begin
                n_rem = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], fits};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = BK_STORE;
                end
            end
            BK_STORE: begin
                n_held[r_lane] = sat_rate;
                if (r_lane == 2'd2) begin
                    n_state = BK_OUT;
                end else begin
                    n_lane  = r_lane + 1'b1;
                    n_state = BK_LOAD;
                end
            end
            BK_OUT: begin
                // wait for the result register to free up
                if (!r_out_full || i_pop) begin
                    n_out_full = 1'b1;
                    if (r_cmd.valid) begin
                        n_out.rate_valid   = 1'b1;
                        n_out.rate_time    = r_cmd.rate_time;
                        n_out.roll_rate    = r_held[0];
                        n_out.pitch_rate   = r_held[1];
                        n_out.heading_rate = r_held[2];
                    end else begin
                        n_out = '0;
                    end
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_out_full <= 1'b0;
            r_held     <= '{default: '0};
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
            r_held     <= n_held;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_cmd  <= n_cmd;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

[src/euler_angle_rate_differentiator_unit.sv]
// ----------------------------------------------------------------------------
// euler_angle_rate_differentiator_unit
// Angular rates of timestamped roll, pitch and heading samples.
// ----------------------------------------------------------------------------
// Each pushed item (three angles, 13 fraction bits, and a tick time; time zero
// flushes) yields one result: the rates of the middle sample of a three-sample
// window, by central difference, forward at stream start and backward on flush,
// heading difference wrapped into plus or minus pi, scaled by 2^RATE_SHIFT and
// saturated to 32 bits. Equal times repeat the previous rates. The front takes
// an item per cycle, while the queue is not full, into a two-entry command
// queue; the back runs one restoring divider, one quotient bit per cycle,
// shared by the three rates, with load, divide and store for each lane and
// then output; items with no rate or equal times go straight to output.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angle_rate_differentiator_unit #(
    parameter int RATE_SHIFT = eard_pkg::RATE_SHIFT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire eard_pkg::t_in_item i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output eard_pkg::t_out_item     o_item,
    output logic                    o_empty
);
    import eard_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_empty;
    logic back_pop;

    eard_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_q_full   (o_full),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push)
    );

    eard_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    eard_back #(
        .RATE_SHIFT (RATE_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_empty (queue_empty),
        .o_cmd_pop   (back_pop),
        .o_item      (o_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop)
    );

endmodule

`default_nettype wire
